// File: hdl/ccks_pkg.sv
// ----------------------------------------------------------------------------
// ccks_pkg
// Shared types, constants and the control store of the click key sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ccks_pkg;

   // Counter and report decode constants
   localparam int unsigned TimerBits    = 16;
   localparam logic [31:0] CounterMax   = 32'((64'd1 << TimerBits) - 64'd1);
   localparam logic [15:0] PageConsumer = 16'h000C;
   localparam logic [15:0] UsageUp      = 16'h00E9;
   localparam logic [15:0] UsageDown    = 16'h00EA;
   localparam logic signed [31:0] PressValue = 32'sd1;
   localparam logic [7:0]  FnKey        = 8'h3F;
   localparam logic [2:0]  MaxMods      = 3'd4;

   typedef enum logic {
      OP_TICK   = 1'b0,
      OP_REPORT = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      CSR_WINDOW_MS   = 3'd0,
      CSR_SINGLE_FORM = 3'd1,
      CSR_SINGLE_KEY  = 3'd2,
      CSR_SINGLE_MODS = 3'd3,
      CSR_DOUBLE_FORM = 3'd4,
      CSR_DOUBLE_KEY  = 3'd5,
      CSR_DOUBLE_MODS = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic               operation;
      logic [15:0]        usage_page;
      logic [15:0]        usage_code;
      logic signed [31:0] report_value;
   } req_word_type;

   typedef struct packed {
      logic [7:0] key_code;
      logic       key_down;
      logic [4:0] modifier_flags;
      logic       click_kind;
      logic       last_event;
   } rsp_word_type;

   // One action: form bit0 = Fn, bit1 = main key; mods = count + four slots
   typedef struct packed {
      logic [1:0]  form;
      logic [7:0]  key;
      logic [10:0] mods;
   } action_type;

   typedef struct packed {
      logic go;
      logic kind;
   } start_type;

   // Control store
   typedef enum logic [2:0] {
      STEP_MOD_DN = 3'd0,
      STEP_FN_DN  = 3'd1,
      STEP_KEY_DN = 3'd2,
      STEP_KEY_UP = 3'd3,
      STEP_FN_UP  = 3'd4,
      STEP_MOD_UP = 3'd5
   } step_type;

   typedef enum logic [1:0] {
      KS_SLOT = 2'd0,
      KS_FN   = 2'd1,
      KS_MAIN = 2'd2
   } key_sel_type;

   typedef enum logic [1:0] {
      FS_ACC_NEXT = 2'd0,
      FS_TAP      = 2'd1,
      FS_ACC      = 2'd2
   } flag_sel_type;

   typedef enum logic [1:0] {
      AO_HOLD  = 2'd0,
      AO_SET   = 2'd1,
      AO_CLEAR = 2'd2
   } acc_op_type;

   typedef enum logic [1:0] {
      IO_HOLD = 2'd0,
      IO_INC  = 2'd1,
      IO_DEC  = 2'd2
   } idx_op_type;

   typedef enum logic [1:0] {
      CD_MORE_MODS = 2'd0,
      CD_FN        = 2'd1,
      CD_KEY_TAP   = 2'd2,
      CD_HELD_MODS = 2'd3
   } cond_type;

   typedef enum logic [1:0] {
      LS_NEVER         = 2'd0,
      LS_NO_MODS_NO_FN = 2'd1,
      LS_NO_MODS       = 2'd2,
      LS_ONE_HELD      = 2'd3
   } last_sel_type;

   typedef struct packed {
      key_sel_type  key_sel;
      logic         key_down;
      flag_sel_type flag_sel;
      acc_op_type   acc_op;
      idx_op_type   idx_op;
      cond_type     cond;
      logic         repeat_step;
      last_sel_type last_sel;
      logic         end_prog;
   } ucode_type;

   function automatic ucode_type ucode(input step_type step);
      ucode_type w;
      w = '{KS_MAIN, 1'b0, FS_ACC, AO_HOLD, IO_HOLD, CD_HELD_MODS, 1'b0, LS_NEVER, 1'b1};
      case (step)
         STEP_MOD_DN: w = '{KS_SLOT, 1'b1, FS_ACC_NEXT, AO_SET, IO_INC,
                            CD_MORE_MODS, 1'b1, LS_NEVER, 1'b0};
         STEP_FN_DN:  w = '{KS_FN, 1'b1, FS_TAP, AO_HOLD, IO_HOLD,
                            CD_FN, 1'b0, LS_NEVER, 1'b0};
         STEP_KEY_DN: w = '{KS_MAIN, 1'b1, FS_TAP, AO_HOLD, IO_HOLD,
                            CD_KEY_TAP, 1'b0, LS_NEVER, 1'b0};
         STEP_KEY_UP: w = '{KS_MAIN, 1'b0, FS_TAP, AO_HOLD, IO_HOLD,
                            CD_KEY_TAP, 1'b0, LS_NO_MODS_NO_FN, 1'b0};
         STEP_FN_UP:  w = '{KS_FN, 1'b0, FS_ACC, AO_HOLD, IO_HOLD,
                            CD_FN, 1'b0, LS_NO_MODS, 1'b0};
         STEP_MOD_UP: w = '{KS_SLOT, 1'b0, FS_ACC_NEXT, AO_CLEAR, IO_DEC,
                            CD_HELD_MODS, 1'b1, LS_ONE_HELD, 1'b1};
         default:     w = '{KS_MAIN, 1'b0, FS_ACC, AO_HOLD, IO_HOLD,
                            CD_HELD_MODS, 1'b0, LS_NEVER, 1'b1};
      endcase
      return w;
   endfunction

   // Modifier slot code to key: ctrl, opt, cmd, shift
   function automatic logic [7:0] mod_key(input logic [1:0] code);
      logic [7:0] k;
      case (code)
         2'd0:    k = 8'd59;
         2'd1:    k = 8'd58;
         2'd2:    k = 8'd55;
         default: k = 8'd56;
      endcase
      return k;
   endfunction

   // Window length into the counter, saturated at the counter's full scale
   function automatic logic [TimerBits-1:0] load_value(input logic [15:0] window);
      logic [31:0] w32;
      w32 = {16'b0, window};
      if (w32 > CounterMax) begin
         w32 = CounterMax;
      end
      return w32[TimerBits-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/ccks_sequencer.sv
// ----------------------------------------------------------------------------
// ccks_sequencer
// Microcoded key-event player with a one-word output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccks_sequencer (
   input  wire                    clock,
   input  wire                    reset,
   input  ccks_pkg::start_type    start,
   input  ccks_pkg::action_type   single_action,
   input  ccks_pkg::action_type   double_action,
   output logic                   busy,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ccks_pkg::rsp_word_type rsp_data
);

   logic                   busy_ff, busy_in;
   ccks_pkg::step_type     step_ff, step_in;
   logic [2:0]             idx_ff, idx_in;
   logic [3:0]             acc_ff, acc_in;
   logic                   kind_ff, kind_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ccks_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   ccks_pkg::ucode_type    uw;
   ccks_pkg::action_type   act;
   logic                   use_fn, has_key;
   logic [2:0]             mod_count;
   logic [2:0]             slot;
   logic [1:0]             code;
   logic [3:0]             code_bit;
   logic [3:0]             acc_next;
   logic                   cond_ok;
   logic                   out_free;
   logic                   fire;
   ccks_pkg::rsp_word_type word;

   always_comb begin
      uw       = ccks_pkg::ucode(step_ff);
      act      = kind_ff ? double_action : single_action;
      use_fn   = act.form[0];
      has_key  = act.form[1];
      mod_count = (act.mods[2:0] > ccks_pkg::MaxMods) ? ccks_pkg::MaxMods : act.mods[2:0];

      // release walks the slots backward
      slot     = (uw.idx_op == ccks_pkg::IO_DEC) ? (idx_ff - 3'd1) : idx_ff;
      code     = act.mods[3 + 2 * slot[1:0] +: 2];
      code_bit = 4'b0001 << code;

      case (uw.acc_op)
         ccks_pkg::AO_SET:   acc_next = acc_ff | code_bit;
         ccks_pkg::AO_CLEAR: acc_next = acc_ff & ~code_bit;
         default:            acc_next = acc_ff;
      endcase

      case (uw.cond)
         ccks_pkg::CD_MORE_MODS: cond_ok = idx_ff < mod_count;
         ccks_pkg::CD_FN:        cond_ok = use_fn;
         ccks_pkg::CD_KEY_TAP:   cond_ok = !use_fn || has_key;
         default:                cond_ok = idx_ff != 3'd0;
      endcase

      case (uw.key_sel)
         ccks_pkg::KS_SLOT: word.key_code = ccks_pkg::mod_key(code);
         ccks_pkg::KS_FN:   word.key_code = ccks_pkg::FnKey;
         default:           word.key_code = act.key;
      endcase

      case (uw.flag_sel)
         ccks_pkg::FS_ACC_NEXT: word.modifier_flags = {1'b0, acc_next};
         ccks_pkg::FS_TAP:      word.modifier_flags = {use_fn, acc_ff};
         default:               word.modifier_flags = {1'b0, acc_ff};
      endcase

      case (uw.last_sel)
         ccks_pkg::LS_NO_MODS_NO_FN: word.last_event = (mod_count == 3'd0) && !use_fn;
         ccks_pkg::LS_NO_MODS:       word.last_event = mod_count == 3'd0;
         ccks_pkg::LS_ONE_HELD:      word.last_event = idx_ff == 3'd1;
         default:                    word.last_event = 1'b0;
      endcase

      word.key_down   = uw.key_down;
      word.click_kind = kind_ff;

      out_free = !rsp_valid_ff || !rsp_stall;
      fire     = busy_ff && cond_ok && out_free;
   end

   // step control
   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      kind_in  = kind_ff;
      if (start.go) begin
         busy_in = 1'b1;
         step_in = ccks_pkg::STEP_MOD_DN;
         idx_in  = 3'd0;
         acc_in  = 4'd0;
         kind_in = start.kind;
      end else if (busy_ff) begin
         if (cond_ok) begin
            // hold the step until the output register can take the word
            if (out_free) begin
               acc_in = acc_next;
               case (uw.idx_op)
                  ccks_pkg::IO_INC: idx_in = idx_ff + 3'd1;
                  ccks_pkg::IO_DEC: idx_in = idx_ff - 3'd1;
                  default:          idx_in = idx_ff;
               endcase
               if (!uw.repeat_step) begin
                  if (uw.end_prog) begin
                     busy_in = 1'b0;
                  end else begin
                     step_in = ccks_pkg::step_type'(step_ff + 3'd1);
                  end
               end
            end
         end else if (uw.end_prog) begin
            busy_in = 1'b0;
         end else begin
            step_in = ccks_pkg::step_type'(step_ff + 3'd1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= ccks_pkg::STEP_MOD_DN;
         idx_ff       <= 3'd0;
         acc_ff       <= 4'd0;
         kind_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !fire)
      else $error("result word overwritten while stalled");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= ccks_pkg::MaxMods)
      else $error("modifier index out of range");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start.go |-> !busy_ff)
      else $error("action started while sequence running");

   a_all_released: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> acc_ff == 4'd0)
      else $error("sequence ended with modifiers held");

endmodule

`default_nettype wire

// File: hdl/click_classifier_key_sequencer.sv
// ----------------------------------------------------------------------------
// click_classifier_key_sequencer
// Single/double click detector that plays a key-event sequence per click.
// ----------------------------------------------------------------------------
// Each request word is a millisecond tick or an HID report. A report on the
// consumer page with usage 0xE9 or 0xEA and value 1 is a pulse: the first
// pulse arms a countdown of window_ms ticks, a second pulse inside the window
// plays the double action, and a countdown that runs out plays the single
// action. An action comes out as 2 to 12 response words: modifier presses,
// the Fn/key tap, modifier releases, the final word flagged by last_event.
// A word that starts an action holds the request side stalled while the
// microcode steps through it: it emits each key event, closes each of the
// two modifier loops as it runs out of slots, and passes each tap step that
// the action's form skips, waiting whenever the response side stalls. A
// finished response word waits in the output register; while it is stalled
// the sequencer holds its next step. The last word of an action does not
// keep the request side stalled.
`default_nettype none

module click_classifier_key_sequencer (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  ccks_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ccks_pkg::rsp_word_type rsp_data,
   input  wire                    csr_write,
   input  wire  [2:0]             csr_index,
   input  wire  [15:0]            csr_wdata
);

   // configuration registers
   logic [15:0] window_ms_ff;
   logic [1:0]  single_form_ff;
   logic [7:0]  single_key_ff;
   logic [10:0] single_mods_ff;
   logic [1:0]  double_form_ff;
   logic [7:0]  double_key_ff;
   logic [10:0] double_mods_ff;

   // click timer
   logic                             pending_ff, pending_in;
   logic [ccks_pkg::TimerBits-1:0]   count_ff, count_in;

   logic                   seq_busy;
   logic                   accept;
   logic                   is_pulse;
   ccks_pkg::start_type    start;
   ccks_pkg::action_type   single_action;
   ccks_pkg::action_type   double_action;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff   <= 16'd600;
         single_form_ff <= 2'd1;
         single_key_ff  <= 8'd0;
         single_mods_ff <= 11'd0;
         double_form_ff <= 2'd3;
         double_key_ff  <= 8'd6;
         double_mods_ff <= 11'd0;
      end else if (csr_write) begin
         case (ccks_pkg::csr_index_type'(csr_index))
            ccks_pkg::CSR_WINDOW_MS:   window_ms_ff   <= csr_wdata;
            ccks_pkg::CSR_SINGLE_FORM: single_form_ff <= csr_wdata[1:0];
            ccks_pkg::CSR_SINGLE_KEY:  single_key_ff  <= csr_wdata[7:0];
            ccks_pkg::CSR_SINGLE_MODS: single_mods_ff <= csr_wdata[10:0];
            ccks_pkg::CSR_DOUBLE_FORM: double_form_ff <= csr_wdata[1:0];
            ccks_pkg::CSR_DOUBLE_KEY:  double_key_ff  <= csr_wdata[7:0];
            ccks_pkg::CSR_DOUBLE_MODS: double_mods_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign single_action = '{single_form_ff, single_key_ff, single_mods_ff};
   assign double_action = '{double_form_ff, double_key_ff, double_mods_ff};

   // stall the request side for the length of a running sequence
   assign req_stall = seq_busy;
   assign accept    = req_valid && !seq_busy;

   always_comb begin
      is_pulse = (req_data.usage_page == ccks_pkg::PageConsumer)
              && (req_data.usage_code inside {ccks_pkg::UsageUp, ccks_pkg::UsageDown})
              && (req_data.report_value == ccks_pkg::PressValue);

      pending_in = pending_ff;
      count_in   = count_ff;
      start      = '{1'b0, 1'b0};

      if (accept) begin
         if (ccks_pkg::op_type'(req_data.operation) == ccks_pkg::OP_TICK) begin
            if (pending_ff) begin
               // window ran out: a zero window fires on the first tick too
               if (count_ff <= ccks_pkg::TimerBits'(1)) begin
                  pending_in = 1'b0;
                  count_in   = '0;
                  start      = '{1'b1, 1'b0};
               end else begin
                  count_in = count_ff - ccks_pkg::TimerBits'(1);
               end
            end
         end else if (is_pulse) begin
            if (!pending_ff) begin
               // arm the window
               pending_in = 1'b1;
               count_in   = ccks_pkg::load_value(window_ms_ff);
            end else begin
               // second pulse in the window: drop the countdown, play double
               pending_in = 1'b0;
               count_in   = '0;
               start      = '{1'b1, 1'b1};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

   ccks_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .single_action (single_action),
      .double_action (double_action),
      .busy          (seq_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      !pending_ff |-> count_ff == '0)
      else $error("countdown running with no click pending");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      start.go |=> !pending_ff)
      else $error("click still pending after action start");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      $past(start.go) |-> req_stall)
      else $error("request accepted during a sequence");

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the single/double click key sequencer.
// ----------------------------------------------------------------------------
// Each request word is mirrored into a local predictor of the click state and
// the control registers. The predictor works out the key-event words that the
// word should cause and queues them. A checker process compares every
// response word, field by field, with the oldest queued event. Directed tests
// cover reset values, modifier saturation, repeated modifier slots, the window
// extremes and reports that are not pulses. Random phases follow, with fresh
// register settings in each. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int         WatchdogLimit = 2000;
   localparam int         TotalWords    = 110;
   localparam int         SettleCycles  = 30;
   localparam int         MaxReports    = 100;
   localparam logic [4:0] FnFlag        = 5'h10;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   ccks_pkg::req_word_type req_data  = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   ccks_pkg::rsp_word_type rsp_data;
   logic                   csr_write = 1'b0;
   logic [2:0]             csr_index = '0;
   logic [15:0]            csr_wdata = '0;

   // Mirror of the control registers
   logic [15:0] window_ms_q;
   logic [1:0]  single_form_q;
   logic [7:0]  single_key_q;
   logic [10:0] single_mods_q;
   logic [1:0]  double_form_q;
   logic [7:0]  double_key_q;
   logic [10:0] double_mods_q;

   // Mirror of the click state
   logic        click_armed;
   logic [15:0] ticks_left;

   // Key events still owed by the block, oldest first
   ccks_pkg::rsp_word_type pending_key_events[$];

   int  mismatches     = 0;
   int  events_checked = 0;
   int  words_sent     = 0;
   int  pulses_seen    = 0;
   int  singles_played = 0;
   int  doubles_played = 0;
   int  quiet_cycles   = 0;
   int  stall_run      = 0;
   int  calm_run       = 0;
   bit  no_gaps        = 1'b0;

   always #5 clock = ~clock;

   click_classifier_key_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Key-event predictor
   // -------------------------------------------------------------------------
   function automatic logic [7:0] modifier_keycode(input logic [1:0] slot_code);
      logic [7:0] k;
      case (slot_code)
         2'd0:    k = 8'd59;   // ctrl
         2'd1:    k = 8'd58;   // opt
         2'd2:    k = 8'd55;   // cmd
         default: k = 8'd56;   // shift
      endcase
      return k;
   endfunction

   function automatic ccks_pkg::rsp_word_type key_event(input logic [7:0] key,
                                                        input logic down,
                                                        input logic [4:0] flags,
                                                        input logic kind);
      ccks_pkg::rsp_word_type ev;
      ev.key_code       = key;
      ev.key_down       = down;
      ev.modifier_flags = flags;
      ev.click_kind     = kind;
      ev.last_event     = 1'b0;
      return ev;
   endfunction

   // Expand one action into its key events and queue them
   function automatic void queue_action(input logic [1:0] form, input logic [7:0] key,
                                        input logic [10:0] mods, input logic kind);
      ccks_pkg::rsp_word_type seq[$];
      logic [4:0]   held;
      logic [4:0]   tap_flags;
      logic [1:0]   slot_code;
      int           count;
      int           i;
      count = mods[2:0];
      // Saturate the modifier count
      if (count > ccks_pkg::MaxMods) begin
         count = ccks_pkg::MaxMods;
      end
      held = '0;
      // Press modifiers in slot order, flags accumulating
      for (i = 0; i < count; i++) begin
         slot_code = mods[3 + 2 * i +: 2];
         held[slot_code] = 1'b1;
         seq.push_back(key_event(modifier_keycode(slot_code), 1'b1, held, kind));
      end
      tap_flags = form[0] ? (held | FnFlag) : held;
      // Fn+key, Fn only, or plain key (also when neither bit is set)
      if (form[0]) begin
         seq.push_back(key_event(ccks_pkg::FnKey, 1'b1, tap_flags, kind));
      end
      if (form[1] || !form[0]) begin
         seq.push_back(key_event(key, 1'b1, tap_flags, kind));
         seq.push_back(key_event(key, 1'b0, tap_flags, kind));
      end
      if (form[0]) begin
         seq.push_back(key_event(ccks_pkg::FnKey, 1'b0, held, kind));
      end
      // Release in reverse slot order; a repeated slot may already show cleared
      for (i = count - 1; i >= 0; i--) begin
         slot_code = mods[3 + 2 * i +: 2];
         held[slot_code] = 1'b0;
         seq.push_back(key_event(modifier_keycode(slot_code), 1'b0, held, kind));
      end
      seq[seq.size() - 1].last_event = 1'b1;
      foreach (seq[n]) begin
         pending_key_events.push_back(seq[n]);
      end
   endfunction

   // Advance the click state by one accepted request word
   function automatic void predict_key_events(input ccks_pkg::req_word_type w);
      if (w.operation == ccks_pkg::OP_TICK) begin
         if (click_armed) begin
            // A zero window fires on the first tick, as a window of one
            if (ticks_left <= 16'd1) begin
               ticks_left  = '0;
               click_armed = 1'b0;
               singles_played++;
               queue_action(single_form_q, single_key_q, single_mods_q, 1'b0);
            end else begin
               ticks_left = ticks_left - 16'd1;
            end
         end
      end else if (w.usage_page == ccks_pkg::PageConsumer
                   && (w.usage_code == ccks_pkg::UsageUp
                       || w.usage_code == ccks_pkg::UsageDown)
                   && w.report_value == ccks_pkg::PressValue) begin
         pulses_seen++;
         if (!click_armed) begin
            click_armed = 1'b1;
            ticks_left  = window_ms_q;
         end else begin
            click_armed = 1'b0;
            ticks_left  = '0;
            doubles_played++;
            queue_action(double_form_q, double_key_q, double_mods_q, 1'b1);
         end
      end
   endfunction

   // -------------------------------------------------------------------------
   // Response checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (mismatches < MaxReports) begin
         $display("%0t ns: %s", $time, msg);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin : check_key_events
      ccks_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_key_events.size() == 0) begin
            report_mismatch($sformatf("key event %h arrived with none expected", rsp_data));
         end else begin
            want = pending_key_events.pop_front();
            events_checked++;
            if (rsp_data.key_code !== want.key_code)
               report_mismatch($sformatf("key_code %h, expected %h",
                                         rsp_data.key_code, want.key_code));
            if (rsp_data.key_down !== want.key_down)
               report_mismatch($sformatf("key_down %b, expected %b",
                                         rsp_data.key_down, want.key_down));
            if (rsp_data.modifier_flags !== want.modifier_flags)
               report_mismatch($sformatf("modifier_flags %b, expected %b",
                                         rsp_data.modifier_flags, want.modifier_flags));
            if (rsp_data.click_kind !== want.click_kind)
               report_mismatch($sformatf("click_kind %b, expected %b",
                                         rsp_data.click_kind, want.click_kind));
            if (rsp_data.last_event !== want.last_event)
               report_mismatch($sformatf("last_event %b, expected %b",
                                         rsp_data.last_event, want.last_event));
         end
      end
   end

   // Response-side stall: short bursts mostly, a few long ones, calm stretches
   always @(posedge clock) begin
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else if (calm_run > 0) begin
         rsp_stall <= 1'b0;
         calm_run  <= calm_run - 1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               rsp_stall <= 1'b1;
               stall_run <= $urandom_range(0, 2);
            end
            4: begin
               rsp_stall <= 1'b1;
               stall_run <= $urandom_range(15, 45);
            end
            5, 6: begin
               rsp_stall <= 1'b0;
               calm_run  <= $urandom_range(10, 40);
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t ns: no handshake for %0d cycles, %0d key events still owed",
                  $time, WatchdogLimit, pending_key_events.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // Send one request word; valid stays high after acceptance so that the
   // next word can follow back to back
   task automatic send_word(input ccks_pkg::req_word_type w);
      int gap;
      gap = 0;
      if (!no_gaps) begin
         case ($urandom_range(0, 19))
            10, 11, 12, 13, 14, 15, 16: gap = $urandom_range(1, 3);
            17, 18:                     gap = $urandom_range(4, 10);
            19:                         gap = $urandom_range(20, 60);
            default:                    gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      // Hold the word until the block takes it
      do @(posedge clock); while (req_stall);
      words_sent++;
      predict_key_events(w);
   endtask

   // Drop valid and wait until every owed key event has come back
   task automatic drain_events();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_key_events.size() != 0);
   endtask

   // Drain, then let the sequencer finish its trailing steps before a write
   task automatic settle_for_write();
      drain_events();
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input ccks_pkg::csr_index_type idx, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         ccks_pkg::CSR_WINDOW_MS:   window_ms_q   = value;
         ccks_pkg::CSR_SINGLE_FORM: single_form_q = value[1:0];
         ccks_pkg::CSR_SINGLE_KEY:  single_key_q  = value[7:0];
         ccks_pkg::CSR_SINGLE_MODS: single_mods_q = value[10:0];
         ccks_pkg::CSR_DOUBLE_FORM: double_form_q = value[1:0];
         ccks_pkg::CSR_DOUBLE_KEY:  double_key_q  = value[7:0];
         ccks_pkg::CSR_DOUBLE_MODS: double_mods_q = value[10:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Request word builders
   // -------------------------------------------------------------------------
   function automatic ccks_pkg::req_word_type report_word(input logic [15:0] page,
                                                          input logic [15:0] usage,
                                                          input logic [31:0] value);
      ccks_pkg::req_word_type w;
      w.operation    = ccks_pkg::OP_REPORT;
      w.usage_page   = page;
      w.usage_code   = usage;
      w.report_value = value;
      return w;
   endfunction

   function automatic ccks_pkg::req_word_type pulse_word();
      return report_word(ccks_pkg::PageConsumer,
                         $urandom_range(0, 1) ? ccks_pkg::UsageUp : ccks_pkg::UsageDown,
                         ccks_pkg::PressValue);
   endfunction

   // Tick fields other than the operation are don't-care; randomize them
   function automatic ccks_pkg::req_word_type tick_word();
      ccks_pkg::req_word_type w;
      w.operation    = ccks_pkg::OP_TICK;
      w.usage_page   = 16'($urandom);
      w.usage_code   = 16'($urandom);
      w.report_value = $urandom;
      return w;
   endfunction

   // A pulse with one field spoiled, or a fully random word
   function automatic ccks_pkg::req_word_type noise_word();
      ccks_pkg::req_word_type w;
      w = pulse_word();
      case ($urandom_range(0, 4))
         0: w.usage_page = 16'($urandom);
         1: w.usage_code = 16'($urandom);
         2: w.report_value = $urandom;
         3: w.report_value = $urandom_range(0, 1) ? 32'sd0 : 32'sd2;
         default: begin
            w = report_word(16'($urandom), 16'($urandom), $urandom);
            w.operation = ccks_pkg::op_type'($urandom_range(0, 1));
         end
      endcase
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Reset values: window 600, single is a bare Fn tap, double is Fn+key 6
   task automatic test_reset_values();
      send_word(pulse_word());
      send_word(tick_word());
      send_word(pulse_word());
      settle_for_write();
      write_reg(ccks_pkg::CSR_WINDOW_MS, 16'd2);
      send_word(pulse_word());
      send_word(tick_word());
      send_word(tick_word());
   endtask

   // Count above four saturates; repeated slots clear early; zero window
   task automatic test_saturation_and_repeats();
      settle_for_write();
      write_reg(ccks_pkg::CSR_WINDOW_MS, 16'd0);
      write_reg(ccks_pkg::CSR_SINGLE_FORM, 16'd0);
      write_reg(ccks_pkg::CSR_SINGLE_KEY, 16'hFF);
      // count 7, slots ctrl, opt, cmd, shift
      write_reg(ccks_pkg::CSR_SINGLE_MODS, {5'd0, 2'd3, 2'd2, 2'd1, 2'd0, 3'd7});
      write_reg(ccks_pkg::CSR_DOUBLE_FORM, 16'd3);
      write_reg(ccks_pkg::CSR_DOUBLE_KEY, 16'h00);
      // count 5, slots opt, opt, shift, ctrl
      write_reg(ccks_pkg::CSR_DOUBLE_MODS, {5'd0, 2'd0, 2'd3, 2'd1, 2'd1, 3'd5});
      send_word(pulse_word());
      send_word(tick_word());
      send_word(pulse_word());
      send_word(pulse_word());
   endtask

   // Widest window with key-only double, then a one-tick window with Fn+key single
   task automatic test_window_extremes();
      settle_for_write();
      write_reg(ccks_pkg::CSR_WINDOW_MS, 16'hFFFF);
      write_reg(ccks_pkg::CSR_DOUBLE_FORM, 16'd2);
      write_reg(ccks_pkg::CSR_DOUBLE_MODS, {5'd0, 2'd0, 2'd0, 2'd0, 2'd3, 3'd1});
      send_word(pulse_word());
      send_word(tick_word());
      send_word(tick_word());
      send_word(pulse_word());
      settle_for_write();
      write_reg(ccks_pkg::CSR_WINDOW_MS, 16'd1);
      write_reg(ccks_pkg::CSR_SINGLE_FORM, 16'd3);
      send_word(pulse_word());
      send_word(tick_word());
   endtask

   // Near misses are ignored, and a tick with nothing armed does nothing
   task automatic test_ignored_reports();
      send_word(tick_word());
      send_word(report_word(ccks_pkg::PageConsumer, ccks_pkg::UsageUp, 32'sd0));
      send_word(report_word(ccks_pkg::PageConsumer, ccks_pkg::UsageDown, -32'sd1));
      send_word(report_word(ccks_pkg::PageConsumer, ccks_pkg::UsageUp, 32'h8000_0001));
      send_word(report_word(16'h000D, ccks_pkg::UsageUp, ccks_pkg::PressValue));
      send_word(report_word(ccks_pkg::PageConsumer, 16'h01E9, ccks_pkg::PressValue));
      send_word(report_word(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF));
   endtask

   // Random phases: new registers, then mostly well-formed clicks
   task automatic test_random_phases();
      int choice;
      int ticks;
      int seq_idx;
      int limit;
      while (words_sent < TotalWords) begin
         // Cancel a click left armed so the next phase starts clean
         if (click_armed) begin
            send_word(pulse_word());
         end
         settle_for_write();
         case ($urandom_range(0, 9))
            0:       write_reg(ccks_pkg::CSR_WINDOW_MS, 16'd0);
            1:       write_reg(ccks_pkg::CSR_WINDOW_MS, 16'hFFFF);
            2:       write_reg(ccks_pkg::CSR_WINDOW_MS, 16'($urandom));
            default: write_reg(ccks_pkg::CSR_WINDOW_MS, 16'($urandom_range(1, 6)));
         endcase
         write_reg(ccks_pkg::CSR_SINGLE_FORM, 16'($urandom_range(0, 3)));
         write_reg(ccks_pkg::CSR_SINGLE_KEY, 16'($urandom_range(0, 255)));
         write_reg(ccks_pkg::CSR_SINGLE_MODS, 16'($urandom_range(0, 2047)));
         write_reg(ccks_pkg::CSR_DOUBLE_FORM, 16'($urandom_range(0, 3)));
         write_reg(ccks_pkg::CSR_DOUBLE_KEY, 16'($urandom_range(0, 255)));
         write_reg(ccks_pkg::CSR_DOUBLE_MODS, 16'($urandom_range(0, 2047)));
         no_gaps = ($urandom_range(0, 3) == 0);
         for (seq_idx = 0; seq_idx < 8 && words_sent < TotalWords; seq_idx++) begin
            choice = $urandom_range(0, 9);
            // A long window cannot run out in reasonable time; play a double
            if (choice >= 4 && choice <= 6 && window_ms_q > 16'd8) begin
               choice = 0;
            end
            case (choice)
               0, 1, 2, 3: begin
                  limit = (window_ms_q > 16'd4) ? 3
                        : (window_ms_q == 16'd0) ? 0 : window_ms_q - 1;
                  ticks = $urandom_range(0, limit);
                  send_word(pulse_word());
                  repeat (ticks) begin
                     if ($urandom_range(0, 3) == 0) begin
                        send_word(noise_word());
                     end
                     send_word(tick_word());
                  end
                  send_word(pulse_word());
               end
               4, 5, 6: begin
                  send_word(pulse_word());
                  while (click_armed) begin
                     if ($urandom_range(0, 4) == 0) begin
                        send_word(noise_word());
                     end
                     send_word(tick_word());
                  end
               end
               7, 8:    send_word(noise_word());
               default: send_word(tick_word());
            endcase
            // Now and then hold off until every owed event is back
            if ($urandom_range(0, 9) == 0) begin
               drain_events();
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      window_ms_q   = 16'd600;
      single_form_q = 2'd1;
      single_key_q  = 8'd0;
      single_mods_q = 11'd0;
      double_form_q = 2'd3;
      double_key_q  = 8'd6;
      double_mods_q = 11'd0;
      click_armed   = 1'b0;
      ticks_left    = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_saturation_and_repeats();
      test_window_extremes();
      test_ignored_reports();
      test_random_phases();

      // Drain, then give stray words a chance to show up
      drain_events();
      repeat (SettleCycles) @(posedge clock);

      $display("Sent %0d request words: %0d pulses, %0d single and %0d double actions",
               words_sent, pulses_seen, singles_played, doubles_played);
      $display("Compared %0d key events field by field, %0d mismatches",
               events_checked, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
